// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define TSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("span unit check failed");

// Next-cycle implication, held off while reset is asserted.
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("span unit check failed");

`endif

// File: rtl/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  localparam int COORD_WIDTH_DEF = 10;
  localparam int NUM_EDGES       = 3;
  localparam int MID_DEPTH       = 4;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VA_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VA_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VB_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VB_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VC_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VC_Y = 3'd5;

  // act, neg, start column, product, divisor
  function automatic int edge_bits(input int w);
    return 2 + 4 * w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tss_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tss_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              pop,
  output logic      [DATA_W-1:0] rd_data,
  output logic                   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign rd_data = rd_data_r;
  assign empty   = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
    // bypass a write into the slot the read pointer moves to
    rd_data_r <= (push && (wr_ptr_r == rd_ptr_nxt)) ? wr_data : mem[rd_ptr_nxt];
  end

endmodule

`default_nettype wire

// File: rtl/tss_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tss_front import tss_pkg::*; #(
  parameter  int W      = COORD_WIDTH_DEF,
  localparam int ITEM_W = NUM_EDGES * edge_bits(W)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [W-1:0]         cfg_data,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [W-1:0]         in_row,
  output logic                      mid_push,
  output logic [ITEM_W-1:0]         mid_data,
  input  wire logic                 mid_pop
);

  localparam int RES_W = $clog2(MID_DEPTH + 1);

  typedef struct packed {
    logic         act;
    logic         neg;
    logic [W-1:0] xa;
    logic [W-1:0] adx;
    logic [W-1:0] t;
    logic [W-1:0] dy;
  } edge_pre_t;

  typedef struct packed {
    logic           act;
    logic           neg;
    logic [W-1:0]   xa;
    logic [2*W-1:0] prod;
    logic [W-1:0]   dy;
  } edge_item_t;

  logic [W-1:0] vx_r [NUM_EDGES];
  logic [W-1:0] vy_r [NUM_EDGES];

  edge_pre_t  [NUM_EDGES-1:0] pre_nxt;
  edge_pre_t  [NUM_EDGES-1:0] pre_r;
  edge_item_t [NUM_EDGES-1:0] item_nxt;
  edge_item_t [NUM_EDGES-1:0] item_r;
  logic                       vld1_r, vld2_r;
  logic [RES_W-1:0]           res_r, res_nxt;
  logic                       in_acc;

  // Vertex registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VA_X: vx_r[0] <= cfg_data;
        REG_VA_Y: vy_r[0] <= cfg_data;
        REG_VB_X: vx_r[1] <= cfg_data;
        REG_VB_Y: vy_r[1] <= cfg_data;
        REG_VC_X: vx_r[2] <= cfg_data;
        REG_VC_Y: vy_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify each edge against the requested row
  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_cls
    localparam int NB = (e + 1) % NUM_EDGES;
    logic [W-1:0] xa, xb, ya, yb, ylo, yhi;
    logic         in_rng;

    assign xa  = vx_r[e];
    assign xb  = vx_r[NB];
    assign ya  = vy_r[e];
    assign yb  = vy_r[NB];
    assign ylo = (ya < yb) ? ya : yb;
    assign yhi = (ya < yb) ? yb : ya;
    // half-open [lower, upper); a horizontal edge has an empty range
    assign in_rng = (in_row >= ylo) && (in_row < yhi);

    assign pre_nxt[e] = '{
      act: in_rng,
      neg: (xb < xa),
      xa:  xa,
      adx: (xb >= xa) ? (xb - xa) : (xa - xb),
      t:   in_rng ? ((in_row >= ya) ? (in_row - ya) : (ya - in_row)) : '0,
      dy:  in_rng ? (yhi - ylo) : W'(1)
    };

    assign item_nxt[e] = '{
      act:  pre_r[e].act,
      neg:  pre_r[e].neg,
      xa:   pre_r[e].xa,
      prod: (2*W)'(pre_r[e].adx) * (2*W)'(pre_r[e].t),
      dy:   pre_r[e].dy
    };
  end

  assign in_acc   = in_push && !in_full;
  assign in_full  = (res_r == RES_W'(MID_DEPTH));
  assign mid_push = vld2_r;
  assign mid_data = item_r;

  // Reserve a queue slot at accept, release it when the back end takes the request
  always_comb begin
    case ({in_acc, mid_pop})
      2'b10:   res_nxt = res_r + 1'b1;
      2'b01:   res_nxt = res_r - 1'b1;
      default: res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      res_r  <= '0;
    end else begin
      vld1_r <= in_acc;
      vld2_r <= vld1_r;
      res_r  <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pre_r  <= pre_nxt;
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/tss_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tss_div import tss_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           in_act,
  input  wire logic           in_neg,
  input  wire logic [W-1:0]   in_xa,
  input  wire logic [2*W-1:0] in_prod,
  input  wire logic [W-1:0]   in_dy,
  output logic                out_act,
  output logic [W-1:0]        out_x
);

  // One quotient bit per stage, MSB first. The last stage keeps no remainder.
  logic [2*W-1:0] rem_r [W-1];
  logic [W-1:0]   dy_r  [W-1];
  logic [W-1:0]   quo_r [W];
  logic           act_r [W];
  logic           neg_r [W];
  logic [W-1:0]   xa_r  [W];
  logic           out_act_r;
  logic [W-1:0]   out_x_r;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [2*W-1:0] rem_in, dsh;
    logic [W-1:0]   dy_in, quo_in, xa_in;
    logic           act_in, neg_in, ge;

    if (k == 0) begin : g_first
      assign rem_in = in_prod;
      assign dy_in  = in_dy;
      assign quo_in = '0;
      assign act_in = in_act;
      assign neg_in = in_neg;
      assign xa_in  = in_xa;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dy_in  = dy_r[k-1];
      assign quo_in = quo_r[k-1];
      assign act_in = act_r[k-1];
      assign neg_in = neg_r[k-1];
      assign xa_in  = xa_r[k-1];
    end

    assign dsh = (2*W)'(dy_in) << (W - 1 - k);
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk) begin
      quo_r[k] <= {quo_in[W-2:0], ge};
      act_r[k] <= act_in;
      neg_r[k] <= neg_in;
      xa_r[k]  <= xa_in;
    end

    if (k < W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? (rem_in - dsh) : rem_in;
        dy_r[k]  <= dy_in;
      end
    end
  end

  // Crossing stays between the edge's end columns, so W bits hold it
  always_ff @(posedge clk) begin
    out_act_r <= act_r[W-1];
    out_x_r   <= neg_r[W-1] ? (xa_r[W-1] - quo_r[W-1]) : (xa_r[W-1] + quo_r[W-1]);
  end

  assign out_act = out_act_r;
  assign out_x   = out_x_r;

endmodule

`default_nettype wire

// File: rtl/tss_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tss_back import tss_pkg::*; #(
  parameter  int W      = COORD_WIDTH_DEF,
  localparam int ITEM_W = NUM_EDGES * edge_bits(W)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              mid_empty,
  input  wire logic [ITEM_W-1:0] mid_data,
  output logic                   mid_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic                   out_span_hit,
  output logic [W-1:0]           out_span_left,
  output logic [W-1:0]           out_span_right
);

  localparam int LAT       = W + 2;
  localparam int OUT_DEPTH = LAT + 2;
  localparam int RES_W     = $clog2(OUT_DEPTH + 1);
  localparam int OUT_W     = 1 + 2 * W;

  typedef struct packed {
    logic           act;
    logic           neg;
    logic [W-1:0]   xa;
    logic [2*W-1:0] prod;
    logic [W-1:0]   dy;
  } edge_item_t;

  typedef struct packed {
    logic         hit;
    logic [W-1:0] left;
    logic [W-1:0] right;
  } span_t;

  edge_item_t [NUM_EDGES-1:0] head;
  logic       [NUM_EDGES-1:0] lane_act;
  logic       [W-1:0]         lane_x [NUM_EDGES];
  logic       [W:0]           vld_r;
  logic       [RES_W-1:0]     res_r, res_nxt;
  logic                       issue, out_acc;
  span_t                      span_wr, span_rd;

  assign head    = mid_data;
  // Issue only with an output slot reserved, so the lanes never stall
  assign issue   = !mid_empty && (res_r != RES_W'(OUT_DEPTH));
  assign mid_pop = issue;
  assign out_acc = out_pop && !out_empty;

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_lane
    tss_div #(.W(W)) u_div (
      .clk     (clk),
      .in_act  (head[e].act),
      .in_neg  (head[e].neg),
      .in_xa   (head[e].xa),
      .in_prod (head[e].prod),
      .in_dy   (head[e].dy),
      .out_act (lane_act[e]),
      .out_x   (lane_x[e])
    );
  end

  // Min and max over the edges that cross the row
  always_comb begin
    span_wr = '0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (lane_act[e]) begin
        if (!span_wr.hit) begin
          span_wr.left  = lane_x[e];
          span_wr.right = lane_x[e];
        end else begin
          if (lane_x[e] < span_wr.left) begin
            span_wr.left = lane_x[e];
          end
          if (lane_x[e] > span_wr.right) begin
            span_wr.right = lane_x[e];
          end
        end
        span_wr.hit = 1'b1;
      end
    end
  end

  always_comb begin
    case ({issue, out_acc})
      2'b10:   res_nxt = res_r + 1'b1;
      2'b01:   res_nxt = res_r - 1'b1;
      default: res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      res_r <= '0;
    end else begin
      vld_r <= {vld_r[W-1:0], issue};
      res_r <= res_nxt;
    end
  end

  tss_fifo #(.DATA_W(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (vld_r[W]),
    .wr_data (span_wr),
    .pop     (out_acc),
    .rd_data (span_rd),
    .empty   (out_empty)
  );

  assign out_span_hit   = span_rd.hit;
  assign out_span_left  = span_rd.left;
  assign out_span_right = span_rd.right;

endmodule

`default_nettype wire

// File: rtl/triangle_scanline_span_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// in_       push / full             row
// out_      empty / pop             span_hit, span_left, span_right
// cfg_      valid / ready           index, data (vertex registers 0..5)
//
// Sustains one row per cycle unless in_full is high or the back end holds issue;
// each span comes from the restoring divider, which resolves one quotient bit per stage.
// Reset is synchronous and returns all vertex registers to zero; no clearing pass.
// in_full rises once the four-slot queue behind the front end is spoken for; the
// back end holds issue when the output queue has no free slot. cfg_ready stays high.

module triangle_scanline_span_top import tss_pkg::*; #(
  parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int ITEM_W      = NUM_EDGES * edge_bits(COORD_WIDTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [COORD_WIDTH-1:0] in_row,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic                        out_span_hit,
  output logic [COORD_WIDTH-1:0]      out_span_left,
  output logic [COORD_WIDTH-1:0]      out_span_right,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COORD_WIDTH-1:0] cfg_data
);

  logic              mid_push, mid_pop, mid_empty;
  logic [ITEM_W-1:0] mid_wr, mid_rd;

  assign cfg_ready = 1'b1;

  tss_front #(.W(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_row    (in_row),
    .mid_push  (mid_push),
    .mid_data  (mid_wr),
    .mid_pop   (mid_pop)
  );

  tss_fifo #(.DATA_W(ITEM_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (mid_wr),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  tss_back #(.W(COORD_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mid_empty      (mid_empty),
    .mid_data       (mid_rd),
    .mid_pop        (mid_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_span_hit   (out_span_hit),
    .out_span_left  (out_span_left),
    .out_span_right (out_span_right)
  );

endmodule

`default_nettype wire

// File: rtl/tss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tss_checker import tss_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_full,
  input wire logic         out_empty,
  input wire logic         out_pop,
  input wire logic         out_span_hit,
  input wire logic [W-1:0] out_span_left,
  input wire logic [W-1:0] out_span_right
);

  // leaving reset: nothing waiting, room to take a request
  `TSS_ASSERT_SAME(a_reset_clean, clk, rst_n, !$past(rst_n), out_empty && !in_full)

  // a waiting result holds until popped
  `TSS_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_span_hit) && $stable(out_span_left) && $stable(out_span_right))

  `TSS_ASSERT_SAME(a_miss_zero, clk, rst_n, !out_empty && !out_span_hit, (out_span_left == '0) && (out_span_right == '0))

  `TSS_ASSERT_SAME(a_span_order, clk, rst_n, !out_empty && out_span_hit, out_span_left <= out_span_right)

endmodule

bind triangle_scanline_span_top tss_checker #(.W(COORD_WIDTH)) u_tss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_span_hit   (out_span_hit),
  .out_span_left  (out_span_left),
  .out_span_right (out_span_right)
);

`default_nettype wire

// File: sim/triangle_scanline_span_top_tb.sv
`timescale 1ns / 1ps

module triangle_scanline_span_top_tb import tss_pkg::*;;

  localparam int W = COORD_WIDTH_DEF;
  localparam logic [W-1:0] COORD_MAX = {W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int LATENCY = W + 4;
  localparam int RANDOM_ROWS = 1150;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [W-1:0] ax, ay, bx, by, cx, cy;
  } tri_t;

  typedef struct packed {
    logic         hit;
    logic [W-1:0] left;
    logic [W-1:0] right;
  } span_t;

  typedef struct {
    tri_t         shape;
    logic [W-1:0] row;
    bit           known;
    span_t        want;
  } probe_t;

  typedef enum int {
    SHAPE_ANY, SHAPE_SMALL, SHAPE_CORNERS, SHAPE_FLAT, SHAPE_SLIVER
  } shape_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [W-1:0]         in_row;
  logic                 out_empty;
  logic                 out_pop;
  logic                 out_span_hit;
  logic [W-1:0]         out_span_left;
  logic [W-1:0]         out_span_right;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [W-1:0]         cfg_data;

  tri_t   cur_tri = '0;
  span_t  pending_spans[$];
  probe_t probes[$];
  bit     steady = 1'b0;
  int     errors = 0;
  int     rows_sent = 0;
  int     spans_checked = 0;
  int     span_hits = 0;
  int     reg_writes = 0;
  int     spare_writes = 0;
  int     shapes_loaded = 0;
  int     cycles = 0;

  triangle_scanline_span_top #(
    .COORD_WIDTH(W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_row        (in_row),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_span_hit  (out_span_hit),
    .out_span_left (out_span_left),
    .out_span_right(out_span_right),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Walk every edge of the triangle; each non-horizontal edge is used for rows in [lower y, upper y).
  function automatic span_t predict_span(tri_t t, logic [W-1:0] r);
    int    xs[3];
    int    ys[3];
    int    e, n, x, y, lo, hi;
    span_t s;
    xs = '{int'(t.ax), int'(t.bx), int'(t.cx)};
    ys = '{int'(t.ay), int'(t.by), int'(t.cy)};
    y = int'(r);
    s = '0;
    lo = 0;
    hi = 0;
    for (e = 0; e < 3; e++) begin
      n = (e == 2) ? 0 : e + 1;
      if (ys[e] != ys[n] &&
          ((ys[e] <= y && y < ys[n]) || (ys[n] <= y && y < ys[e]))) begin
        // int division truncates toward zero
        x = xs[e] + ((xs[n] - xs[e]) * (y - ys[e])) / (ys[n] - ys[e]);
        if (!s.hit) begin
          s.hit = 1'b1;
          lo = x;
          hi = x;
        end else begin
          if (x < lo) lo = x;
          if (x > hi) hi = x;
        end
      end
    end
    if (s.hit) begin
      s.left = lo[W-1:0];
      s.right = hi[W-1:0];
    end
    return s;
  endfunction

  function automatic tri_t make_shape(shape_kind_t k);
    tri_t t;
    int   x0, y0;
    x0 = $urandom_range(0, COORD_MAX - 16);
    y0 = $urandom_range(0, COORD_MAX - 16);
    t.ax = W'($urandom_range(0, COORD_MAX));
    t.ay = W'($urandom_range(0, COORD_MAX));
    t.bx = W'($urandom_range(0, COORD_MAX));
    t.by = W'($urandom_range(0, COORD_MAX));
    t.cx = W'($urandom_range(0, COORD_MAX));
    t.cy = W'($urandom_range(0, COORD_MAX));
    case (k)
      SHAPE_SMALL: begin
        t.ax = W'(x0 + $urandom_range(0, 16));
        t.bx = W'(x0 + $urandom_range(0, 16));
        t.cx = W'(x0 + $urandom_range(0, 16));
        t.ay = W'(y0 + $urandom_range(0, 16));
        t.by = W'(y0 + $urandom_range(0, 16));
        t.cy = W'(y0 + $urandom_range(0, 16));
      end
      SHAPE_CORNERS: begin
        t.ax = $urandom_range(0, 1) ? COORD_MAX : '0;
        t.ay = $urandom_range(0, 1) ? COORD_MAX : '0;
        t.bx = $urandom_range(0, 1) ? COORD_MAX : '0;
        t.by = $urandom_range(0, 1) ? COORD_MAX : '0;
        t.cx = $urandom_range(0, 1) ? COORD_MAX : '0;
        t.cy = $urandom_range(0, 1) ? COORD_MAX : '0;
      end
      SHAPE_FLAT: begin
        t.by = t.ay;
        if ($urandom_range(0, 1)) t.cy = t.ay;
      end
      SHAPE_SLIVER: begin
        t.ax = W'(x0 + $urandom_range(0, 3));
        t.bx = W'(x0 + $urandom_range(0, 3));
        t.cx = W'(x0 + $urandom_range(0, 3));
      end
      default: ;
    endcase
    return t;
  endfunction

  // Mostly rows inside the triangle's vertical extent, some on vertices, some anywhere.
  function automatic logic [W-1:0] pick_row(tri_t t);
    int lo, hi, sel;
    lo = int'(t.ay);
    hi = int'(t.ay);
    if (int'(t.by) < lo) lo = int'(t.by);
    if (int'(t.by) > hi) hi = int'(t.by);
    if (int'(t.cy) < lo) lo = int'(t.cy);
    if (int'(t.cy) > hi) hi = int'(t.cy);
    sel = $urandom_range(0, 9);
    if (sel < 7) return W'($urandom_range(lo, hi));
    if (sel == 7) begin
      case ($urandom_range(0, 2))
        0: return t.ay;
        1: return t.by;
        default: return t.cy;
      endcase
    end
    return W'($urandom_range(0, COORD_MAX));
  endfunction

  task automatic add_probe(input tri_t t, input logic [W-1:0] r, input bit known,
                           input logic hit, input logic [W-1:0] l, input logic [W-1:0] rt);
    probe_t p;
    p.shape = t;
    p.row = r;
    p.known = known;
    p.want = '{hit: hit, left: l, right: rt};
    probes.push_back(p);
  endtask

  task automatic send_row(input logic [W-1:0] r, input bit known, input span_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_row <= r;
    do @(posedge clk); while (in_full !== 1'b0);
    pending_spans.push_back(known ? want : predict_span(cur_tri, r));
    rows_sent++;
    @(negedge clk);
  endtask

  // Hold requests until every expected span has been popped.
  task automatic drain_spans;
    in_push <= 1'b0;
    @(negedge clk);
    while (pending_spans.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_VA_X: cur_tri.ax = d;
      REG_VA_Y: cur_tri.ay = d;
      REG_VB_X: cur_tri.bx = d;
      REG_VB_Y: cur_tri.by = d;
      REG_VC_X: cur_tri.cx = d;
      REG_VC_Y: cur_tri.cy = d;
      default: spare_writes++;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic load_triangle(input tri_t t);
    logic [CFG_IDX_W-1:0] spare;
    drain_spans();
    spare = $urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7;
    if ($urandom_range(0, 1)) write_reg(spare, W'($urandom));
    write_reg(REG_VA_X, t.ax);
    write_reg(REG_VA_Y, t.ay);
    write_reg(REG_VB_X, t.bx);
    write_reg(REG_VB_Y, t.by);
    write_reg(REG_VC_X, t.cx);
    write_reg(REG_VC_Y, t.cy);
    if ($urandom_range(0, 1)) write_reg(spare, W'($urandom));
    cfg_valid <= 1'b0;
    shapes_loaded++;
  endtask

  always @(posedge clk) begin
    span_t want;
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected span: hit %0d left %0d right %0d",
               out_span_hit, out_span_left, out_span_right);
        errors++;
      end else begin
        want = pending_spans.pop_front();
        spans_checked++;
        if (out_span_hit) span_hits++;
        if (out_span_hit !== want.hit) begin
          $error("span_hit: expected %0d, got %0d", want.hit, out_span_hit);
          errors++;
        end
        if (out_span_left !== want.left) begin
          $error("span_left: expected %0d, got %0d", want.left, out_span_left);
          errors++;
        end
        if (out_span_right !== want.right) begin
          $error("span_right: expected %0d, got %0d", want.right, out_span_right);
          errors++;
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    out_pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      wait_cycles = steady ? 0 : $urandom_range(0, 10);
      if (wait_cycles != 0) begin
        out_pop <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      @(negedge clk);
    end
  end

  initial begin
    tri_t        t_zero, t_diag, t_flat, t_edge, t_trunc, t_line, t_apex;
    probe_t      p;
    shape_kind_t kind;
    int          len, i, phase;

    rst_n = 1'b0;
    in_push = 1'b0;
    in_row = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    t_zero  = '0;
    t_diag  = '{ax: '0,        ay: '0,  bx: COORD_MAX, by: COORD_MAX, cx: '0,        cy: COORD_MAX};
    t_flat  = '{ax: '0,        ay: 500, bx: 300,       by: 500,       cx: COORD_MAX, cy: 500};
    t_edge  = '{ax: COORD_MAX, ay: '0,  bx: '0,        by: COORD_MAX, cx: COORD_MAX, cy: COORD_MAX};
    t_trunc = '{ax: 10,        ay: 0,   bx: 0,         by: 3,         cx: 10,        cy: 3};
    t_line  = '{ax: 5,         ay: 100, bx: 5,         by: 200,       cx: 5,         cy: 300};
    t_apex  = '{ax: 100,       ay: 900, bx: 900,       by: 900,       cx: 500,       cy: 100};

    // reset vertices: everything is flat, nothing hits
    add_probe(t_zero,  0,         1, 1'b0, 0, 0);
    add_probe(t_zero,  COORD_MAX, 1, 1'b0, 0, 0);
    add_probe(t_diag,  0,         1, 1'b1, 0, 0);
    add_probe(t_diag,  1022,      1, 1'b1, 0, 1022);
    add_probe(t_diag,  COORD_MAX, 1, 1'b0, 0, 0);
    add_probe(t_diag,  512,       0, 1'b0, 0, 0);
    add_probe(t_flat,  500,       1, 1'b0, 0, 0);
    add_probe(t_flat,  499,       1, 1'b0, 0, 0);
    add_probe(t_edge,  0,         1, 1'b1, COORD_MAX, COORD_MAX);
    add_probe(t_edge,  1,         1, 1'b1, 1022, COORD_MAX);
    add_probe(t_edge,  700,       0, 1'b0, 0, 0);
    // negative slope: quotient truncates toward zero, not down
    add_probe(t_trunc, 0,         1, 1'b1, 10, 10);
    add_probe(t_trunc, 1,         1, 1'b1, 7, 10);
    add_probe(t_trunc, 2,         1, 1'b1, 4, 10);
    add_probe(t_trunc, 3,         1, 1'b0, 0, 0);
    add_probe(t_line,  150,       1, 1'b1, 5, 5);
    add_probe(t_line,  250,       0, 1'b0, 0, 0);
    add_probe(t_line,  300,       1, 1'b0, 0, 0);
    add_probe(t_apex,  100,       1, 1'b1, 500, 500);
    add_probe(t_apex,  899,       0, 1'b0, 0, 0);
    add_probe(t_apex,  900,       1, 1'b0, 0, 0);
    add_probe(t_apex,  50,        1, 1'b0, 0, 0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (probes[k]) begin
      p = probes[k];
      if (p.shape != cur_tri) load_triangle(p.shape);
      send_row(p.row, p.known, p.want);
    end

    phase = 0;
    while (rows_sent < probes.size() + RANDOM_ROWS) begin
      kind = shape_kind_t'($urandom_range(0, 4));
      if (phase % 3 == 0) kind = SHAPE_ANY;
      load_triangle(make_shape(kind));
      steady = ($urandom_range(0, 3) == 0);
      len = $urandom_range(20, 60);
      for (i = 0; i < len; i++) begin
        if (i == len / 2 && phase % 5 == 2) drain_spans();
        send_row(pick_row(cur_tri), 1'b0, '0);
      end
      phase++;
    end
    steady = 1'b0;

    drain_spans();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Requested %0d rows over %0d triangles; %0d spans checked, %0d of them hits.",
             rows_sent, shapes_loaded, spans_checked, span_hits);
    $display("Issued %0d vertex register writes, %0d of them to unmapped indices.",
             reg_writes, spare_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
